### hw/rtl/ccs_pkg.sv
// shared types and constants for the closed cardinal spline evaluator
`timescale 1ns / 1ps
package ccs_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned RateW     = 32;
  localparam int unsigned TightW    = 16;
  localparam int unsigned CountW    = 9;
  localparam int unsigned PidxW     = 8;
  localparam int unsigned SegW      = 8;
  localparam int unsigned CfgAddrW  = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ProdW     = TimeW + RateW;
  localparam int unsigned FracW     = 24;
  localparam int unsigned QuotW     = ProdW - FracW;
  localparam int unsigned UW        = 16;
  localparam int unsigned ULsb      = FracW - UW;
  localparam int unsigned HW        = 20;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned ModStages = QuotW / DigitBits;
  localparam int unsigned FifoDepth = 4;

  localparam logic signed [TightW-1:0] TightReset = 16'sd2048;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_POINT_COUNT = 8'd0,
    CFG_START_TIME  = 8'd1,
    CFG_RATE        = 8'd2,
    CFG_TIGHTNESS   = 8'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef struct packed {
    logic [CountW-1:0]        point_count;
    logic [TimeW-1:0]         start_time;
    logic [RateW-1:0]         rate;
    logic signed [TightW-1:0] tightness;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    op_e              op;
    logic [PidxW-1:0] addr;
    point_t           pt;
    logic [TimeW-1:0] time_ms;
  } work_t;

endpackage

### hw/rtl/ccs_if.sv
// valid/ready channel interfaces for input words, result words and config writes
`timescale 1ns / 1ps
interface ccs_in_if;
  import ccs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [PidxW-1:0]         point_index;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  logic [TimeW-1:0]         time_ms;
  modport source (output valid, operation, point_index, point_x, point_y, point_z, time_ms,
                  input ready);
  modport sink (input valid, operation, point_index, point_x, point_y, point_z, time_ms,
                output ready);
endinterface

interface ccs_out_if;
  import ccs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic [SegW-1:0]          segment;
  modport source (output valid, pos_x, pos_y, pos_z, segment, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, segment, output ready);
endinterface

interface ccs_cfg_if;
  import ccs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ccs_fifo.sv
// small queue between the front and the back
`timescale 1ns / 1ps
module ccs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = $clog2(Depth);

  logic [AW:0]      wr_q, rd_q;
  logic [Width-1:0] mem_q [Depth];

  assign full_o  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign data_o  = mem_q[rd_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[AW-1:0]] <= data_i;
  end

endmodule

### hw/rtl/ccs_blend.sv
// per-axis tangent, hermite blend and saturation pipeline
`timescale 1ns / 1ps
module ccs_blend (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ccs_pkg::CoordW-1:0] p_i [4],
  input  logic signed [ccs_pkg::TightW-1:0] k_i,
  input  logic signed [ccs_pkg::HW-1:0]     h_i [4],
  output logic signed [ccs_pkg::CoordW-1:0] pos_o
);
  import ccs_pkg::*;

  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned TanProdW = DiffW + TightW;
  localparam int unsigned TanShift = 12;
  localparam int unsigned TanW     = TanProdW - TanShift;
  localparam int unsigned MulPW    = CoordW + HW;
  localparam int unsigned MulTW    = TanW + HW;
  localparam int unsigned SumW     = MulTW + 2;
  localparam int unsigned PosShift = 16;
  localparam logic signed [SumW-1:0] SatMax = {{(SumW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = ~SatMax;

  logic signed [DiffW-1:0]    d1, d2;
  logic signed [TanProdW-1:0] tp1, tp2;
  logic signed [TanW-1:0]     t1_d, t2_d, t1_q, t2_q;
  logic signed [CoordW-1:0]   p1_q, p2_q;
  logic signed [HW-1:0]       h_q [4];
  logic signed [MulPW-1:0]    m1_q, m2_q;
  logic signed [MulTW-1:0]    m3_q, m4_q;
  logic signed [SumW-1:0]     sum, shifted;
  logic signed [CoordW-1:0]   pos_d;

  always_comb begin
    d1   = DiffW'(p_i[2]) - DiffW'(p_i[0]);
    d2   = DiffW'(p_i[3]) - DiffW'(p_i[1]);
    tp1  = TanProdW'(d1) * TanProdW'(k_i);
    tp2  = TanProdW'(d2) * TanProdW'(k_i);
    t1_d = TanW'(tp1 >>> TanShift);
    t2_d = TanW'(tp2 >>> TanShift);
  end

  always_comb begin
    sum     = SumW'(m1_q) + SumW'(m2_q) + SumW'(m3_q) + SumW'(m4_q);
    shifted = sum >>> PosShift;
    if (shifted > SatMax) begin
      pos_d = SatMax[CoordW-1:0];
    end else if (shifted < SatMin) begin
      pos_d = SatMin[CoordW-1:0];
    end else begin
      pos_d = shifted[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t1_d;
      t2_q  <= t2_d;
      p1_q  <= p_i[1];
      p2_q  <= p_i[2];
      h_q   <= h_i;
      m1_q  <= MulPW'(p1_q) * MulPW'(h_q[0]);
      m2_q  <= MulPW'(p2_q) * MulPW'(h_q[1]);
      m3_q  <= MulTW'(t1_q) * MulTW'(h_q[2]);
      m4_q  <= MulTW'(t2_q) * MulTW'(h_q[3]);
      pos_o <= pos_d;
    end
  end

endmodule

### hw/rtl/ccs_front.sv
// front: config registers, input acceptance and classification of words
`timescale 1ns / 1ps
module ccs_front #(
  parameter int unsigned MaxPoints = 256,
  parameter int unsigned CntW      = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ccs_in_if.sink          in_i,
  ccs_cfg_if.sink         cfg_i,
  output ccs_pkg::cfg_t   cfg_o,
  output logic [CntW-1:0] n_o,
  output logic            push_o,
  output ccs_pkg::work_t  word_o,
  input  logic            full_i
);
  import ccs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  vld_q, vld_d;
  work_t word_q, word_d;
  logic  accept, keep, is_load;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_POINT_COUNT: cfg_d.point_count = cfg_i.data[CountW-1:0];
        CFG_START_TIME:  cfg_d.start_time  = cfg_i.data[TimeW-1:0];
        CFG_RATE:        cfg_d.rate        = cfg_i.data[RateW-1:0];
        CFG_TIGHTNESS:   cfg_d.tightness   = signed'(cfg_i.data[TightW-1:0]);
        default: ;
      endcase
    end
  end

  // active count clipped to the store depth
  always_comb begin
    if (32'(cfg_q.point_count) > 32'(MaxPoints)) begin
      n_o = CntW'(MaxPoints);
    end else begin
      n_o = CntW'(cfg_q.point_count);
    end
  end

  assign push_o     = vld_q & ~full_i;
  assign in_i.ready = ~vld_q | ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign is_load    = (op_e'(in_i.operation) == OP_LOAD);
  assign keep       = is_load ? (32'(in_i.point_index) < 32'(MaxPoints))
                              : (n_o >= CntW'(2));
  assign word_o     = word_q;

  always_comb begin
    word_d.op      = op_e'(in_i.operation);
    word_d.addr    = in_i.point_index;
    word_d.pt.x    = in_i.point_x;
    word_d.pt.y    = in_i.point_y;
    word_d.pt.z    = in_i.point_z;
    word_d.time_ms = in_i.time_ms;
    if (accept) begin
      vld_d = keep;
    end else if (push_o) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q                 <= 1'b0;
      cfg_q.point_count     <= '0;
      cfg_q.start_time      <= '0;
      cfg_q.rate            <= '0;
      cfg_q.tightness       <= TightReset;
    end else begin
      vld_q <= vld_d;
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) word_q <= word_d;
  end

endmodule

### hw/rtl/ccs_back.sv
// back: time product, pipelined segment modulo, point store and blend lanes
`timescale 1ns / 1ps
module ccs_back #(
  parameter int unsigned MaxPoints = 256,
  parameter int unsigned CntW      = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ccs_pkg::cfg_t   cfg_i,
  input  logic [CntW-1:0] n_i,
  input  ccs_pkg::work_t  word_i,
  input  logic            empty_i,
  output logic            pop_o,
  ccs_out_if.source       out_o
);
  import ccs_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam logic signed [HW-1:0] HOne = HW'(32'sd65536);

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] addr;
    point_t          pt;
    logic [QuotW-1:0] dvd;
    logic [CntW-1:0] rem;
    logic [UW-1:0]   u;
    logic [UW-1:0]   u2;
    logic [UW-1:0]   u3;
  } mst_t;

  function automatic logic [CntW-1:0] mod_step(input logic [CntW-1:0] r, input logic b,
                                               input logic [CntW-1:0] n);
    logic [CntW:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t[CntW-1:0];
  endfunction

  logic                en;
  logic [TimeW-1:0]    elapsed;
  logic [ProdW-1:0]    prod;
  mst_t                m0_d;
  mst_t                m_q   [ModStages+1];
  mst_t                m_d   [ModStages];
  logic                m_vld_q [ModStages+1];

  logic [CntW:0]       nw, idxw, ip1w, ip2w, im1w;
  logic signed [HW-1:0] su, su2, su3;
  logic signed [HW-1:0] h_d [4];

  logic                b_vld_q;
  op_e                 b_op_q;
  logic [IdxW-1:0]     b_addr_q;
  point_t              b_pt_q;
  logic [IdxW-1:0]     b_ra_q [4];
  logic [IdxW-1:0]     b_seg_q;
  logic signed [HW-1:0] b_h_q [4];

  point_t              mem_lo [MaxPoints];
  point_t              mem_hi [MaxPoints];
  point_t              c_rd_q [4];
  logic                c_vld_q, d_vld_q, e_vld_q, out_vld_q;
  logic [IdxW-1:0]     c_seg_q, d_seg_q, e_seg_q, out_seg_q;
  logic signed [HW-1:0] c_h_q [4];

  logic signed [CoordW-1:0] px [4], py [4], pz [4];

  assign en    = ~out_vld_q | out_o.ready;
  assign pop_o = en & ~empty_i;

  // time product
  always_comb begin
    elapsed = word_i.time_ms - cfg_i.start_time;
    prod    = ProdW'(elapsed) * ProdW'(cfg_i.rate);
    m0_d.op   = word_i.op;
    m0_d.addr = IdxW'(word_i.addr);
    m0_d.pt   = word_i.pt;
    m0_d.dvd  = prod[ProdW-1:FracW];
    m0_d.rem  = '0;
    m0_d.u    = prod[ULsb +: UW];
    m0_d.u2   = '0;
    m0_d.u3   = '0;
  end

  // segment modulo, one digit per stage, with u powers alongside
  for (genvar g = 0; g < ModStages; g++) begin : g_mod
    logic [CntW-1:0] r;
    always_comb begin
      m_d[g] = m_q[g];
      r      = m_q[g].rem;
      for (int b = 0; b < DigitBits; b++) begin
        r = mod_step(r, m_q[g].dvd[QuotW-1-g*DigitBits-b], n_i);
      end
      m_d[g].rem = r;
      if (g == 0) m_d[g].u2 = UW'((32'(m_q[g].u) * 32'(m_q[g].u)) >> UW);
      if (g == 1) m_d[g].u3 = UW'((32'(m_q[g].u2) * 32'(m_q[g].u)) >> UW);
    end
  end

  // neighbour addresses and basis weights
  always_comb begin
    nw   = {1'b0, n_i};
    idxw = {1'b0, m_q[ModStages].rem};
    im1w = (idxw == '0) ? (nw - 1'b1) : (idxw - 1'b1);
    ip1w = idxw + 1'b1;
    if (ip1w >= nw) ip1w = ip1w - nw;
    ip2w = idxw + 2'd2;
    if (ip2w >= nw) ip2w = ip2w - nw;
    su     = signed'({{(HW-UW){1'b0}}, m_q[ModStages].u});
    su2    = signed'({{(HW-UW){1'b0}}, m_q[ModStages].u2});
    su3    = signed'({{(HW-UW){1'b0}}, m_q[ModStages].u3});
    h_d[0] = (su3 <<< 1) - (su2 + (su2 <<< 1)) + HOne;
    h_d[1] = (su2 + (su2 <<< 1)) - (su3 <<< 1);
    h_d[2] = su3 - (su2 <<< 1) + su;
    h_d[3] = su3 - su2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= '{default: 1'b0};
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q[0] <= pop_o;
      for (int i = 0; i < ModStages; i++) m_vld_q[i+1] <= m_vld_q[i];
      b_vld_q   <= m_vld_q[ModStages];
      c_vld_q   <= b_vld_q && (b_op_q == OP_EVAL);
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      out_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= m0_d;
      for (int i = 0; i < ModStages; i++) m_q[i+1] <= m_d[i];
      b_op_q    <= m_q[ModStages].op;
      b_addr_q  <= m_q[ModStages].addr;
      b_pt_q    <= m_q[ModStages].pt;
      b_ra_q[0] <= IdxW'(im1w);
      b_ra_q[1] <= IdxW'(idxw);
      b_ra_q[2] <= IdxW'(ip1w);
      b_ra_q[3] <= IdxW'(ip2w);
      b_seg_q   <= IdxW'(idxw);
      b_h_q     <= h_d;
      c_seg_q   <= b_seg_q;
      c_h_q     <= b_h_q;
      d_seg_q   <= c_seg_q;
      e_seg_q   <= d_seg_q;
      out_seg_q <= e_seg_q;
    end
  end

  // point store, two copies for four reads per cycle while the back is not held
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (b_vld_q && (b_op_q == OP_LOAD)) begin
        mem_lo[b_addr_q] <= b_pt_q;
        mem_hi[b_addr_q] <= b_pt_q;
      end
      c_rd_q[0] <= mem_lo[b_ra_q[0]];
      c_rd_q[1] <= mem_lo[b_ra_q[1]];
      c_rd_q[2] <= mem_hi[b_ra_q[2]];
      c_rd_q[3] <= mem_hi[b_ra_q[3]];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = c_rd_q[i].x;
      py[i] = c_rd_q[i].y;
      pz[i] = c_rd_q[i].z;
    end
  end

  ccs_blend u_blend_x (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (px),
    .k_i   (cfg_i.tightness),
    .h_i   (c_h_q),
    .pos_o (out_o.pos_x)
  );

  ccs_blend u_blend_y (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (py),
    .k_i   (cfg_i.tightness),
    .h_i   (c_h_q),
    .pos_o (out_o.pos_y)
  );

  ccs_blend u_blend_z (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (pz),
    .k_i   (cfg_i.tightness),
    .h_i   (c_h_q),
    .pos_o (out_o.pos_z)
  );

  assign out_o.valid   = out_vld_q;
  assign out_o.segment = SegW'(out_seg_q);

endmodule

### hw/rtl/closed_cardinal_spline_eval.sv
// Closed cardinal spline evaluator: position on a ring of 3D control points.
// in_i carries one word per handshake: operation 0 loads a Q16.16 point at
// point_index, operation 1 evaluates the position at time_ms. out_o returns
// pos_x/pos_y/pos_z (Q16.16, saturated) and segment for every evaluate word
// while point_count is at least 2; loads and inactive evaluates give nothing.
// cfg_i writes point_count, start_time, rate and tightness by index 0 to 3,
// always ready; write only while no word is in flight.
// One word is accepted per cycle while the queue has room. An evaluate word
// passes through the input register, queue, 32x32 time product, ten stages of
// the segment modulo (four quotient bits each), address stage, store read,
// tangent, product and sum stages.
// The back pipeline holds as a whole while a result waits on out_o; the
// front register and a four-word queue keep taking input meanwhile.
// Reset clears control and config (tightness to 0.5); point store contents
// are undefined until loaded, and no clearing pass runs.
`timescale 1ns / 1ps
module closed_cardinal_spline_eval #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_in_if.sink    in_i,
  ccs_out_if.source out_o,
  ccs_cfg_if.sink   cfg_i
);
  import ccs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  cfg_t            cfg;
  logic [CntW-1:0] n;
  logic            push, full, pop, empty;
  work_t           front_word, back_word;

  ccs_front #(
    .MaxPoints (MAX_POINTS),
    .CntW      (CntW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .n_o    (n),
    .push_o (push),
    .word_o (front_word),
    .full_i (full)
  );

  ccs_fifo #(
    .Width ($bits(work_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_word),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_word),
    .empty_o (empty)
  );

  ccs_back #(
    .MaxPoints (MAX_POINTS),
    .CntW      (CntW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .n_i     (n),
    .word_i  (back_word),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### test/tb_ccs_if.sv
// testbench-side channel interfaces are taken from the rtl; this file holds the test item types
`timescale 1ns / 1ps
package tb_ccs_pkg;
  import ccs_pkg::*;

  typedef struct packed {
    op_e                      op;
    logic [PidxW-1:0]         idx;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [TimeW-1:0]         tms;
  } spline_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [SegW-1:0]          seg;
  } position_t;
endpackage

### test/tb.sv
// testbench for the closed cardinal spline evaluator: random and directed words, scoreboard
`timescale 1ns / 1ps
module tb;
  import ccs_pkg::*;
  import tb_ccs_pkg::*;

  localparam int NPts = 256;
  localparam int WatchLimit = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();
  ccs_cfg_if cfg_if ();

  closed_cardinal_spline_eval u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  logic signed [CoordW-1:0] pts_x [NPts];
  logic signed [CoordW-1:0] pts_y [NPts];
  logic signed [CoordW-1:0] pts_z [NPts];
  logic [CountW-1:0]        m_count;
  logic [TimeW-1:0]         m_start;
  logic [RateW-1:0]         m_rate;
  logic signed [TightW-1:0] m_tight;

  spline_word_t pending_words[$];
  position_t    expected_pos[$];
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [63:0] fl_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] blend_axis(
      logic signed [31:0] p0, p1, p2, p3, logic signed [63:0] h1, h2, h3, h4);
    logic signed [63:0] k, t1, t2, sum, r;
    k = m_tight;
    t1 = fl_shift((64'(p2) - 64'(p0)) * k, 12);
    t2 = fl_shift((64'(p3) - 64'(p1)) * k, 12);
    sum = 64'(p1) * h1 + 64'(p2) * h2 + t1 * h3 + t2 * h4;
    r = fl_shift(sum, 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_position(spline_word_t w);
    int n, i0, im, i1, i2;
    logic [31:0] el;
    logic [63:0] prod, u, u2, u3;
    logic signed [63:0] h1, h2, h3, h4;
    position_t p;
    if (w.op == OP_LOAD) begin
      pts_x[w.idx] = w.x;
      pts_y[w.idx] = w.y;
      pts_z[w.idx] = w.z;
      return;
    end
    n = (m_count > NPts) ? NPts : m_count;
    if (n < 2) return;
    el = w.tms - m_start;
    prod = 64'(el) * 64'(m_rate);
    i0 = int'((prod >> 24) % n);
    u = (prod >> 8) & 64'hFFFF;
    im = (i0 == 0) ? n - 1 : i0 - 1;
    i1 = (i0 + 1 >= n) ? i0 + 1 - n : i0 + 1;
    i2 = (i0 + 2 >= n) ? i0 + 2 - n : i0 + 2;
    u2 = (u * u) >> 16;
    u3 = (u2 * u) >> 16;
    h1 = 2 * $signed(u3) - 3 * $signed(u2) + 65536;
    h2 = -2 * $signed(u3) + 3 * $signed(u2);
    h3 = $signed(u3) - 2 * $signed(u2) + $signed(u);
    h4 = $signed(u3) - $signed(u2);
    p.x = blend_axis(pts_x[im], pts_x[i0], pts_x[i1], pts_x[i2], h1, h2, h3, h4);
    p.y = blend_axis(pts_y[im], pts_y[i0], pts_y[i1], pts_y[i2], h1, h2, h3, h4);
    p.z = blend_axis(pts_z[im], pts_z[i0], pts_z[i1], pts_z[i2], h1, h2, h3, h4);
    p.seg = i0[7:0];
    expected_pos.push_back(p);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 0;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_position({op_e'(in_if.operation), in_if.point_index, in_if.point_x,
                          in_if.point_y, in_if.point_z, in_if.time_ms});
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 0;
        end else if (pending_words.size() > 0) begin
          spline_word_t w;
          w = pending_words.pop_front();
          in_if.valid       <= 1;
          in_if.operation   <= w.op;
          in_if.point_index <= w.idx;
          in_if.point_x     <= w.x;
          in_if.point_y     <= w.y;
          in_if.point_z     <= w.z;
          in_if.time_ms     <= w.tms;
          gap_left <= pick_gap();
        end else begin
          in_if.valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 0;
      stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pos.size() == 0) begin
          report_mismatch("unexpected word", out_if.segment, 0);
        end else begin
          position_t e;
          e = expected_pos.pop_front();
          if (out_if.pos_x !== e.x) report_mismatch("pos_x", out_if.pos_x, e.x);
          if (out_if.pos_y !== e.y) report_mismatch("pos_y", out_if.pos_y, e.y);
          if (out_if.pos_z !== e.z) report_mismatch("pos_z", out_if.pos_z, e.z);
          if (out_if.segment !== e.seg) report_mismatch("segment", out_if.segment, e.seg);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= 1;
        stall_left <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (pending_words.size() == 0 && expected_pos.size() == 0 && !in_if.valid
            && !cfg_if.valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e i, logic [31:0] d);
    @(posedge clk_i);
    cfg_if.valid <= 1;
    cfg_if.index <= i;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 0;
    case (i)
      CFG_POINT_COUNT: m_count = d[CountW-1:0];
      CFG_START_TIME:  m_start = d;
      CFG_RATE:        m_rate  = d;
      CFG_TIGHTNESS:   m_tight = d[TightW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_load(int i, logic [31:0] x, y, z);
    spline_word_t w;
    w = '{OP_LOAD, i[7:0], x, y, z, $urandom()};
    pending_words.push_back(w);
  endtask

  task automatic push_eval(logic [31:0] t);
    spline_word_t w;
    w = '{OP_EVAL, 8'($urandom()), $urandom(), $urandom(), $urandom(), t};
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] rnd_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFFFFFF;
    if (r == 1) return 32'h80000000;
    if (r < 5) return $urandom();
    return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
  endfunction

  // every word accepted and every result seen, then let loads settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || expected_pos.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(int cnt, logic [31:0] st, logic [31:0] rt, logic [15:0] tg,
                           int nwords);
    int lim;
    write_reg(CFG_POINT_COUNT, cnt);
    write_reg(CFG_START_TIME, st);
    write_reg(CFG_RATE, rt);
    write_reg(CFG_TIGHTNESS, 32'(tg));
    lim = (cnt > NPts) ? NPts : cnt;
    for (int i = 0; i < lim; i++) push_load(i, rnd_coord(), rnd_coord(), rnd_coord());
    for (int j = 0; j < nwords; j++) begin
      if ($urandom_range(0, 9) == 0) push_load($urandom_range(0, lim > 0 ? lim - 1 : 0),
                                                rnd_coord(), rnd_coord(), rnd_coord());
      else push_eval($urandom());
    end
    drain();
  endtask

  initial begin
    in_if.valid = 0; in_if.operation = 0; in_if.point_index = 0;
    in_if.point_x = 0; in_if.point_y = 0; in_if.point_z = 0; in_if.time_ms = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = CFG_POINT_COUNT; cfg_if.data = 0;
    m_count = 0; m_start = 0; m_rate = 0; m_tight = TightReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed: inactive evaluate, load while inactive, extremes
    push_eval(32'h0);
    push_eval(32'hFFFFFFFF);
    push_load(0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
    push_load(1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    push_load(2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000);
    push_load(3, 32'h80000000, 32'h80000000, 32'hFFFF0000);
    drain();
    write_reg(CFG_POINT_COUNT, 2);
    write_reg(CFG_RATE, 32'hFFFFFFFF);
    write_reg(CFG_TIGHTNESS, 32'h7FFF);
    push_eval(32'h0);
    push_eval(32'hFFFFFFFF);
    push_eval(32'h1);
    drain();
    write_reg(CFG_POINT_COUNT, 4);
    write_reg(CFG_TIGHTNESS, 32'h8000);
    for (int i = 0; i < 6; i++) push_eval($urandom());
    push_eval(32'h7FFFFFFF);
    drain();
    // random phases, including count above store size and full ring
    run_phase(2, 0, 32'h00400000, 16'd2048, 80);
    run_phase(3, $urandom(), $urandom(), 16'h0000, 80);
    run_phase(511, $urandom(), $urandom(), 16'($urandom()), 120);
    run_phase(256, 32'hFFFFFFFF, 32'h01000000, 16'h7FFF, 80);
    run_phase(1, $urandom(), $urandom(), 16'h8000, 30);
    run_phase($urandom_range(2, 20), $urandom(), $urandom(), 16'($urandom()), 120);
    run_phase($urandom_range(2, 255), $urandom(), 32'hFFFFFFFF, 16'($urandom()), 120);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
